// File: sv/osa_pkg.sv
package osa_pkg;

   localparam int VOL_WIDTH      = 512;
   localparam int VOL_HEIGHT     = 512;
   localparam int VOL_DEPTH      = 512;
   localparam int ANGLE_BITS     = 12;
   localparam int TRIG_FRAC_BITS = 14;

   localparam int HALF_WIDTH  = VOL_WIDTH / 2;
   localparam int HALF_HEIGHT = VOL_HEIGHT / 2;
   localparam int HALF_DEPTH  = VOL_DEPTH / 2;
   localparam int PLANE_SIZE  = VOL_WIDTH * VOL_HEIGHT;

   localparam int PIXEL_W     = 9;
   localparam int OFFSET_W    = 11;
   localparam int SLICE_W     = 9;
   localparam int ANGLE_W     = 12;
   localparam int ADDR_W      = 27;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam int COORD_W    = 16;
   localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
   localparam int MAG_W      = TRIG_FRAC_BITS + 1;
   localparam int PROD_W     = COORD_W + TRIG_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int TRIG_BIAS  = (1 << TRIG_FRAC_BITS) - 1;
   localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
   localparam int ROM_ADDR_W = ANGLE_BITS - 1;

   localparam int X_IDX_W = (VOL_WIDTH > 1) ? $clog2(VOL_WIDTH) : 1;
   localparam int Y_IDX_W = (VOL_HEIGHT > 1) ? $clog2(VOL_HEIGHT) : 1;
   localparam int Z_IDX_W = (VOL_DEPTH > 1) ? $clog2(VOL_DEPTH) : 1;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned TAYLOR_DIV [7] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VIEW_X_OFFSET,
      CSR_VIEW_Y_OFFSET,
      CSR_SLICE_POSITION,
      CSR_ANGLE_XY_PLANE,
      CSR_ANGLE_XZ_PLANE,
      CSR_ANGLE_YZ_PLANE
   } csr_index_type;

   typedef enum logic [1:0] {
      TRIG_IDLE,
      TRIG_READ,
      TRIG_DRAIN
   } trig_state_type;

   typedef enum logic [2:0] {
      SEL_XY_SIN,
      SEL_XY_COS,
      SEL_XZ_SIN,
      SEL_XZ_COS,
      SEL_YZ_SIN,
      SEL_YZ_COS
   } trig_sel_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_col;
      logic [PIXEL_W-1:0] pixel_row;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] voxel_address;
      logic              inside_res;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] xy_sin;
      logic signed [TRIG_W-1:0] xy_cos;
      logic signed [TRIG_W-1:0] xz_sin;
      logic signed [TRIG_W-1:0] xz_cos;
      logic signed [TRIG_W-1:0] yz_sin;
      logic signed [TRIG_W-1:0] yz_cos;
   } trig_type;

   typedef logic [QUARTER:0][MAG_W-1:0] sine_rom_type;

   // Quarter-wave sine in Q1.TRIG_FRAC_BITS, from a truncated Taylor series in Q2.30.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type      rom;
      longint unsigned   r;
      longint unsigned   u;
      longint unsigned   t;
      longint            sum;
      int                i;
      rom = '0;
      for (r = 0; r <= QUARTER; r++) begin
         u   = (r * HALF_PI_Q30 + (64'd1 << (ANGLE_BITS - 3))) >> (ANGLE_BITS - 2);
         t   = u;
         sum = longint'(u);
         for (i = 0; i < 7; i++) begin
            t = (((t * u) >> 30) * u) >> 30;
            t = t / TAYLOR_DIV[i];
            if (i[0] == 1'b0) begin
               sum = sum - longint'(t);
            end else begin
               sum = sum + longint'(t);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         rom[r] = MAG_W'((sum + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS));
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// File: sv/oblique_slice_address.sv
// Oblique slice address generator: each request word carries one output pixel (column, row);
// the response word gives the linear address of the nearest voxel, or zero with inside_res
// clear when the rotated point leaves the volume. The datapath is a nine-stage pipeline (entry,
// three rotations of a multiply stage and a sum stage each, bounds check, address) that takes
// one pixel per cycle whenever req_ready is high and returns the results in order.
// Sines and cosines are held in registers and refreshed from a single-port quarter-wave table,
// six lookups in turn: req_ready stays low after reset and after each write to an angle register
// until the lookups and the drain state are done, and while a register write is being offered.
module oblique_slice_address (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  osa_pkg::req_payload_type         req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output osa_pkg::rsp_payload_type         rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [osa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [osa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import osa_pkg::*;

   logic signed [OFFSET_W-1:0] view_x_offset_ff, view_x_offset_in;
   logic signed [OFFSET_W-1:0] view_y_offset_ff, view_y_offset_in;
   logic [SLICE_W-1:0]         slice_position_ff, slice_position_in;
   logic [ANGLE_W-1:0]         turn_xy_ff, turn_xy_in;
   logic [ANGLE_W-1:0]         turn_xz_ff, turn_xz_in;
   logic [ANGLE_W-1:0]         turn_yz_ff, turn_yz_in;
   logic                       csr_write;
   logic                       angle_write;

   trig_type                   trig;
   logic                       trig_busy;

   logic                       s0_ready;
   logic                       s0_valid_ff, s0_valid_in;
   logic signed [COORD_W-1:0]  s0_x_ff, s0_x_in;
   logic signed [COORD_W-1:0]  s0_y_ff, s0_y_in;
   logic signed [COORD_W-1:0]  s0_z_ff, s0_z_in;
   logic                       req_accept;

   logic                       xy_in_ready, xy_valid, xz_in_ready, xz_valid;
   logic                       yz_in_ready, yz_valid;
   logic signed [COORD_W-1:0]  x1, y1, z1, x2, y2, z2, x3, y3, z3;

   logic                       s7_ready;
   logic                       s7_valid_ff, s7_valid_in;
   logic signed [COORD_W-1:0]  sx, sy, sz;
   logic                       s7_inside_ff, s7_inside_in;
   logic [X_IDX_W-1:0]         s7_x_ff, s7_x_in;
   logic [Y_IDX_W-1:0]         s7_y_ff, s7_y_in;
   logic [Z_IDX_W-1:0]         s7_z_ff, s7_z_in;

   logic                       s8_ready;
   logic                       s8_valid_ff, s8_valid_in;
   rsp_payload_type            s8_data_ff, s8_data_in;

   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign angle_write = csr_write && ((csr_index == CSR_ANGLE_XY_PLANE) ||
                                      (csr_index == CSR_ANGLE_XZ_PLANE) ||
                                      (csr_index == CSR_ANGLE_YZ_PLANE));

   always_comb begin
      view_x_offset_in  = view_x_offset_ff;
      view_y_offset_in  = view_y_offset_ff;
      slice_position_in = slice_position_ff;
      turn_xy_in        = turn_xy_ff;
      turn_xz_in        = turn_xz_ff;
      turn_yz_in        = turn_yz_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_VIEW_X_OFFSET:  view_x_offset_in  = OFFSET_W'(csr_wdata);
            CSR_VIEW_Y_OFFSET:  view_y_offset_in  = OFFSET_W'(csr_wdata);
            CSR_SLICE_POSITION: slice_position_in = SLICE_W'(csr_wdata);
            CSR_ANGLE_XY_PLANE: turn_xy_in        = ANGLE_W'(csr_wdata);
            CSR_ANGLE_XZ_PLANE: turn_xz_in        = ANGLE_W'(csr_wdata);
            CSR_ANGLE_YZ_PLANE: turn_yz_in        = ANGLE_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_x_offset_ff  <= '0;
         view_y_offset_ff  <= '0;
         slice_position_ff <= SLICE_W'(256);
         turn_xy_ff        <= '0;
         turn_xz_ff        <= '0;
         turn_yz_ff        <= '0;
      end else begin
         view_x_offset_ff  <= view_x_offset_in;
         view_y_offset_ff  <= view_y_offset_in;
         slice_position_ff <= slice_position_in;
         turn_xy_ff        <= turn_xy_in;
         turn_xz_ff        <= turn_xz_in;
         turn_yz_ff        <= turn_yz_in;
      end
   end

   osa_trig u_trig (
      .clock    (clock),
      .reset    (reset),
      .refresh  (angle_write),
      .turn_xy  (turn_xy_ff),
      .turn_xz  (turn_xz_ff),
      .turn_yz  (turn_yz_ff),
      .trig     (trig),
      .busy     (trig_busy)
   );

   assign s0_ready   = !s0_valid_ff || xy_in_ready;
   assign req_ready  = s0_ready && !trig_busy && !csr_valid;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      s0_valid_in = s0_ready ? req_accept : s0_valid_ff;
      s0_x_in = COORD_W'(signed'({1'b0, req_data.pixel_col})) + COORD_W'(view_x_offset_ff)
              - COORD_W'(HALF_WIDTH);
      s0_y_in = COORD_W'(signed'({1'b0, req_data.pixel_row})) + COORD_W'(view_y_offset_ff)
              - COORD_W'(HALF_HEIGHT);
      s0_z_in = COORD_W'(signed'({1'b0, slice_position_ff})) - COORD_W'(HALF_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (s0_ready) begin
         s0_x_ff <= s0_x_in;
         s0_y_ff <= s0_y_in;
         s0_z_ff <= s0_z_in;
      end
   end

   // Each rotation yields p = a*cos - b*sin and q = a*sin + b*cos; c passes through.
   osa_rotate u_rot_xy (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_ready  (xy_in_ready),
      .src_a     (s0_x_ff),
      .src_b     (s0_y_ff),
      .src_c     (s0_z_ff),
      .cos_val   (trig.xy_cos),
      .sin_val   (trig.xy_sin),
      .out_valid (xy_valid),
      .out_ready (xz_in_ready),
      .dst_p     (x1),
      .dst_q     (y1),
      .dst_c     (z1)
   );

   osa_rotate u_rot_xz (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xy_valid),
      .in_ready  (xz_in_ready),
      .src_a     (z1),
      .src_b     (x1),
      .src_c     (y1),
      .cos_val   (trig.xz_cos),
      .sin_val   (trig.xz_sin),
      .out_valid (xz_valid),
      .out_ready (yz_in_ready),
      .dst_p     (z2),
      .dst_q     (x2),
      .dst_c     (y2)
   );

   osa_rotate u_rot_yz (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xz_valid),
      .in_ready  (yz_in_ready),
      .src_a     (y2),
      .src_b     (z2),
      .src_c     (x2),
      .cos_val   (trig.yz_cos),
      .sin_val   (trig.yz_sin),
      .out_valid (yz_valid),
      .out_ready (s7_ready),
      .dst_p     (y3),
      .dst_q     (z3),
      .dst_c     (x3)
   );

   assign s7_ready = !s7_valid_ff || s8_ready;

   always_comb begin
      s7_valid_in  = s7_ready ? yz_valid : s7_valid_ff;
      sx = x3 + COORD_W'(HALF_WIDTH);
      sy = y3 + COORD_W'(HALF_HEIGHT);
      sz = z3 + COORD_W'(HALF_DEPTH);
      s7_inside_in = (sx >= 0) && (sx < COORD_W'(VOL_WIDTH)) &&
                     (sy >= 0) && (sy < COORD_W'(VOL_HEIGHT)) &&
                     (sz >= 0) && (sz < COORD_W'(VOL_DEPTH));
      s7_x_in = sx[X_IDX_W-1:0];
      s7_y_in = sy[Y_IDX_W-1:0];
      s7_z_in = sz[Z_IDX_W-1:0];
   end

   assign s8_ready = !s8_valid_ff || rsp_ready;

   always_comb begin
      s8_valid_in = s8_ready ? s7_valid_ff : s8_valid_ff;
      s8_data_in.inside_res = s7_inside_ff;
      if (s7_inside_ff) begin
         s8_data_in.voxel_address = ADDR_W'(s7_z_ff) * ADDR_W'(PLANE_SIZE)
                                  + ADDR_W'(s7_y_ff) * ADDR_W'(VOL_WIDTH)
                                  + ADDR_W'(s7_x_ff);
      end else begin
         s8_data_in.voxel_address = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s7_valid_ff <= s7_valid_in;
         s8_valid_ff <= s8_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s7_ready) begin
         s7_inside_ff <= s7_inside_in;
         s7_x_ff      <= s7_x_in;
         s7_y_ff      <= s7_y_in;
         s7_z_ff      <= s7_z_in;
      end
      if (s8_ready) begin
         s8_data_ff <= s8_data_in;
      end
   end

   assign rsp_valid = s8_valid_ff;
   assign rsp_data  = s8_data_ff;

endmodule

// File: sv/osa_sine_rom.sv
module osa_sine_rom (
   input  logic                            clock,
   input  logic [osa_pkg::ROM_ADDR_W-1:0]  rom_addr,
   output logic [osa_pkg::MAG_W-1:0]       rom_data_ff
);
   import osa_pkg::*;

   logic [MAG_W-1:0] rom_data_in;

   assign rom_data_in = SINE_ROM[rom_addr];

   always_ff @(posedge clock) begin
      rom_data_ff <= rom_data_in;
   end

endmodule

// File: sv/osa_trig.sv
module osa_trig (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         refresh,
   input  logic [osa_pkg::ANGLE_W-1:0]  turn_xy,
   input  logic [osa_pkg::ANGLE_W-1:0]  turn_xz,
   input  logic [osa_pkg::ANGLE_W-1:0]  turn_yz,
   output osa_pkg::trig_type            trig,
   output logic                         busy
);
   import osa_pkg::*;

   trig_state_type          state_ff, state_in;
   trig_sel_type            sel_ff, sel_in;
   logic                    rd_valid_ff, rd_valid_in;
   trig_sel_type            rd_sel_ff, rd_sel_in;
   logic                    rd_neg_ff, rd_neg_in;
   trig_type                trig_ff, trig_in;
   logic [ANGLE_W-1:0]      angle;
   logic                    is_cos;
   logic [ANGLE_BITS-1:0]   idx;
   logic [1:0]              quad;
   logic [ANGLE_BITS-3:0]   resid;
   logic [ROM_ADDR_W-1:0]   rom_addr;
   logic [MAG_W-1:0]        rom_data;
   logic signed [TRIG_W-1:0] value;

   osa_sine_rom u_rom (
      .clock       (clock),
      .rom_addr    (rom_addr),
      .rom_data_ff (rom_data)
   );

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      if (refresh) begin
         state_in = TRIG_READ;
         sel_in   = SEL_XY_SIN;
      end else begin
         unique case (state_ff)
            TRIG_IDLE: begin
            end
            TRIG_READ: begin
               if (sel_ff == SEL_YZ_COS) begin
                  state_in = TRIG_DRAIN;
               end else begin
                  sel_in = trig_sel_type'(3'(sel_ff + 3'd1));
               end
            end
            TRIG_DRAIN: begin
               state_in = TRIG_IDLE;
            end
            default: begin
               state_in = TRIG_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      unique case (sel_ff) inside
         SEL_XY_SIN, SEL_XY_COS: angle = turn_xy;
         SEL_XZ_SIN, SEL_XZ_COS: angle = turn_xz;
         SEL_YZ_SIN, SEL_YZ_COS: angle = turn_yz;
         default:                angle = '0;
      endcase
      is_cos = (sel_ff == SEL_XY_COS) || (sel_ff == SEL_XZ_COS) || (sel_ff == SEL_YZ_COS);
      idx    = ANGLE_BITS'(angle) + (is_cos ? ANGLE_BITS'(QUARTER) : ANGLE_BITS'(0));
      quad   = idx[ANGLE_BITS-1 -: 2];
      resid  = idx[ANGLE_BITS-3:0];
      // Odd quadrants run the quarter wave backwards; the upper half is negated.
      rom_addr = quad[0] ? ROM_ADDR_W'(QUARTER) - ROM_ADDR_W'(resid) : ROM_ADDR_W'(resid);
      rd_valid_in = (state_ff == TRIG_READ);
      rd_sel_in   = sel_ff;
      rd_neg_in   = quad[1];
   end

   always_comb begin
      value   = rd_neg_ff ? -TRIG_W'(rom_data) : TRIG_W'(rom_data);
      trig_in = trig_ff;
      if (rd_valid_ff) begin
         unique case (rd_sel_ff)
            SEL_XY_SIN: trig_in.xy_sin = value;
            SEL_XY_COS: trig_in.xy_cos = value;
            SEL_XZ_SIN: trig_in.xz_sin = value;
            SEL_XZ_COS: trig_in.xz_cos = value;
            SEL_YZ_SIN: trig_in.yz_sin = value;
            SEL_YZ_COS: trig_in.yz_cos = value;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= TRIG_READ;
         sel_ff      <= SEL_XY_SIN;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sel_ff      <= sel_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_sel_ff <= rd_sel_in;
      rd_neg_ff <= rd_neg_in;
      trig_ff   <= trig_in;
   end

   assign trig = trig_ff;
   assign busy = (state_ff != TRIG_IDLE);

endmodule

// File: sv/osa_rotate.sv
module osa_rotate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [osa_pkg::COORD_W-1:0]  src_a,
   input  logic signed [osa_pkg::COORD_W-1:0]  src_b,
   input  logic signed [osa_pkg::COORD_W-1:0]  src_c,
   input  logic signed [osa_pkg::TRIG_W-1:0]   cos_val,
   input  logic signed [osa_pkg::TRIG_W-1:0]   sin_val,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [osa_pkg::COORD_W-1:0]  dst_p,
   output logic signed [osa_pkg::COORD_W-1:0]  dst_q,
   output logic signed [osa_pkg::COORD_W-1:0]  dst_c
);
   import osa_pkg::*;

   logic                      prod_ready;
   logic                      prod_valid_ff, prod_valid_in;
   logic signed [PROD_W-1:0]  ac_ff, ac_in;
   logic signed [PROD_W-1:0]  bs_ff, bs_in;
   logic signed [PROD_W-1:0]  as_ff, as_in;
   logic signed [PROD_W-1:0]  bc_ff, bc_in;
   logic signed [COORD_W-1:0] pc_ff;

   logic                      sum_ready;
   logic                      sum_valid_ff, sum_valid_in;
   logic signed [COORD_W-1:0] p_ff, p_in;
   logic signed [COORD_W-1:0] q_ff, q_in;
   logic signed [COORD_W-1:0] c_ff;

   // Division by the trig scale, rounding toward zero.
   function automatic logic signed [COORD_W-1:0] scale_down(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] biased;
      biased = v[SUM_W-1] ? v + SUM_W'(TRIG_BIAS) : v;
      return COORD_W'(biased >>> TRIG_FRAC_BITS);
   endfunction

   assign prod_ready = !prod_valid_ff || sum_ready;
   assign sum_ready  = !sum_valid_ff || out_ready;
   assign in_ready   = prod_ready;

   always_comb begin
      prod_valid_in = prod_ready ? in_valid : prod_valid_ff;
      ac_in = PROD_W'(src_a) * PROD_W'(cos_val);
      bs_in = PROD_W'(src_b) * PROD_W'(sin_val);
      as_in = PROD_W'(src_a) * PROD_W'(sin_val);
      bc_in = PROD_W'(src_b) * PROD_W'(cos_val);
   end

   always_comb begin
      sum_valid_in = sum_ready ? prod_valid_ff : sum_valid_ff;
      p_in = scale_down(SUM_W'(ac_ff) - SUM_W'(bs_ff));
      q_in = scale_down(SUM_W'(as_ff) + SUM_W'(bc_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         sum_valid_ff  <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready) begin
         ac_ff <= ac_in;
         bs_ff <= bs_in;
         as_ff <= as_in;
         bc_ff <= bc_in;
         pc_ff <= src_c;
      end
      if (sum_ready) begin
         p_ff <= p_in;
         q_ff <= q_in;
         c_ff <= pc_ff;
      end
   end

   assign out_valid = sum_valid_ff;
   assign dst_p     = p_ff;
   assign dst_q     = q_ff;
   assign dst_c     = c_ff;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import osa_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int BLOCK_ITEMS    = 25;
   localparam longint TRIG_ONE   = longint'(1) << TRIG_FRAC_BITS;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = CSR_INDEX_W'(CSR_ANGLE_YZ_PLANE + 1);

   typedef struct {
      logic signed [OFFSET_W-1:0] x_off;
      logic signed [OFFSET_W-1:0] y_off;
      logic [SLICE_W-1:0]         slice;
      logic [ANGLE_W-1:0]         a_xy;
      logic [ANGLE_W-1:0]         a_xz;
      logic [ANGLE_W-1:0]         a_yz;
   } view_setting_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   req_payload_type         req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   rsp_payload_type         rsp_data;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   view_setting_type        active_view;
   rsp_payload_type         expected_voxels[$];
   longint                  quarter_wave[0:QUARTER];
   int                      send_idle_pct;
   int                      rsp_stall_pct;
   int                      rsp_hold_cycles;
   int                      quiet_cycles;
   int                      failures;
   int                      pixels_sent;
   int                      results_checked;
   int                      inside_hits;
   int                      csr_writes;

   oblique_slice_address uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Quarter-wave sine in Q1.14, from the Taylor series evaluated in Q2.30.
   function automatic longint quarter_sine_q(int r);
      longint unsigned arc;
      longint unsigned term;
      longint          acc;
      arc  = (longint'(r) * HALF_PI_Q30 + (64'd1 << (ANGLE_BITS - 3))) >> (ANGLE_BITS - 2);
      term = arc;
      acc  = longint'(arc);
      for (int n = 1; n <= 7; n++) begin
         term = (((term * arc) >> 30) * arc) >> 30;
         term = term / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return (acc + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
   endfunction

   function automatic longint sine_at(int step);
      int     idx;
      int     quadrant;
      int     r;
      longint mag;
      idx      = step & ((1 << ANGLE_BITS) - 1);
      quadrant = idx >> (ANGLE_BITS - 2);
      r        = idx & (QUARTER - 1);
      mag      = (quadrant % 2 == 1) ? quarter_wave[QUARTER - r] : quarter_wave[r];
      return (quadrant >= 2) ? -mag : mag;
   endfunction

   function automatic longint turn(longint a, longint ca, longint b, longint cb);
      return (a * ca + b * cb) / TRIG_ONE;
   endfunction

   function automatic rsp_payload_type locate_voxel(view_setting_type s, req_payload_type px);
      longint          x, y, z, nx, ny, nz, sn, cs, addr;
      rsp_payload_type res;
      x  = longint'(px.pixel_col) + longint'(s.x_off) - HALF_WIDTH;
      y  = longint'(px.pixel_row) + longint'(s.y_off) - HALF_HEIGHT;
      z  = longint'(s.slice) - HALF_DEPTH;
      sn = sine_at(int'(s.a_xy));
      cs = sine_at(int'(s.a_xy) + QUARTER);
      nx = turn(x, cs, y, -sn);
      ny = turn(x, sn, y, cs);
      x  = nx;
      y  = ny;
      sn = sine_at(int'(s.a_xz));
      cs = sine_at(int'(s.a_xz) + QUARTER);
      nx = turn(x, cs, z, sn);
      nz = turn(x, -sn, z, cs);
      x  = nx;
      z  = nz;
      sn = sine_at(int'(s.a_yz));
      cs = sine_at(int'(s.a_yz) + QUARTER);
      ny = turn(y, cs, z, -sn);
      nz = turn(y, sn, z, cs);
      x  = x + HALF_WIDTH;
      y  = ny + HALF_HEIGHT;
      z  = nz + HALF_DEPTH;
      res = '0;
      if (x >= 0 && x < VOL_WIDTH && y >= 0 && y < VOL_HEIGHT && z >= 0 && z < VOL_DEPTH) begin
         addr              = z * PLANE_SIZE + y * VOL_WIDTH + x;
         res.voxel_address = addr[ADDR_W-1:0];
         res.inside_res    = 1'b1;
      end
      return res;
   endfunction

   function automatic logic [ANGLE_W-1:0] random_angle();
      case ($urandom_range(0, 2))
         0: return '0;
         1: return ANGLE_W'(int'($urandom_range(0, 128)) - 64);
         default: return ANGLE_W'($urandom);
      endcase
   endfunction

   function automatic view_setting_type random_view();
      view_setting_type s;
      if ($urandom_range(0, 3) == 0) begin
         s.x_off = OFFSET_W'($urandom);
         s.y_off = OFFSET_W'($urandom);
      end else begin
         s.x_off = OFFSET_W'(int'($urandom_range(0, 1024)) - 512);
         s.y_off = OFFSET_W'(int'($urandom_range(0, 1024)) - 512);
      end
      s.slice = SLICE_W'($urandom);
      s.a_xy  = random_angle();
      s.a_xz  = random_angle();
      s.a_yz  = random_angle();
      return s;
   endfunction

   task automatic note_mismatch(input string what, input longint got, input longint want);
      failures++;
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] col, input logic [PIXEL_W-1:0] row);
      req_payload_type word;
      word.pixel_col = col;
      word.pixel_row = row;
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (!req_ready);
      expected_voxels.push_back(locate_voxel(active_view, word));
      pixels_sent++;
   endtask

   task automatic send_corners();
      send_pixel('0, '0);
      send_pixel('1, '0);
      send_pixel('0, '1);
      send_pixel('1, '1);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_voxels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_VIEW_X_OFFSET:  active_view.x_off = data[OFFSET_W-1:0];
         CSR_VIEW_Y_OFFSET:  active_view.y_off = data[OFFSET_W-1:0];
         CSR_SLICE_POSITION: active_view.slice = data[SLICE_W-1:0];
         CSR_ANGLE_XY_PLANE: active_view.a_xy  = data[ANGLE_W-1:0];
         CSR_ANGLE_XZ_PLANE: active_view.a_xz  = data[ANGLE_W-1:0];
         CSR_ANGLE_YZ_PLANE: active_view.a_yz  = data[ANGLE_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // With noise set, the unused upper bits carry random values and an unmapped
   // index is written as well; neither may change the view.
   task automatic program_view(input view_setting_type s, input bit with_noise);
      logic [CSR_DATA_W-1:0] noise;
      noise = with_noise ? CSR_DATA_W'($urandom) : '0;
      write_register(CSR_VIEW_X_OFFSET, {noise[CSR_DATA_W-1:OFFSET_W], s.x_off});
      write_register(CSR_VIEW_Y_OFFSET, {noise[CSR_DATA_W-1:OFFSET_W], s.y_off});
      if (with_noise) begin
         write_register(CSR_SPARE + CSR_INDEX_W'($urandom_range(0, 1)), noise);
      end
      write_register(CSR_SLICE_POSITION, {noise[CSR_DATA_W-1:SLICE_W], s.slice});
      write_register(CSR_ANGLE_XY_PLANE, s.a_xy);
      write_register(CSR_ANGLE_XZ_PLANE, s.a_xz);
      write_register(CSR_ANGLE_YZ_PLANE, s.a_yz);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_view();
      send_corners();
      send_pixel(PIXEL_W'(HALF_WIDTH), PIXEL_W'(HALF_HEIGHT));
      drain_results();
   endtask

   task automatic test_view_extremes();
      view_setting_type s;
      s = '{x_off: 11'sd1023, y_off: -11'sd1024, slice: '1,
            a_xy: '1, a_xz: 12'd1, a_yz: 12'd2048};
      program_view(s, 1'b0);
      send_corners();
      drain_results();
      s = '{x_off: -11'sd512, y_off: 11'sd512, slice: '0,
            a_xy: 12'd1024, a_xz: 12'd3072, a_yz: '0};
      program_view(s, 1'b0);
      send_corners();
      drain_results();
   endtask

   task automatic test_rotated_corners();
      view_setting_type s;
      s = '{x_off: '0, y_off: '0, slice: 9'd256, a_xy: 12'd512, a_xz: '0, a_yz: '0};
      program_view(s, 1'b0);
      send_corners();
      send_pixel(PIXEL_W'(HALF_WIDTH), PIXEL_W'(HALF_HEIGHT));
      drain_results();
   endtask

   task automatic test_register_masking();
      view_setting_type s;
      s = '{x_off: 11'sd5, y_off: -11'sd7, slice: 9'd300, a_xy: 12'd16, a_xz: '0, a_yz: 12'd4000};
      program_view(s, 1'b1);
      send_pixel(9'd100, 9'd200);
      send_pixel(9'd400, 9'd50);
      drain_results();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int items);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int done = 0; done < items; done += BLOCK_ITEMS) begin
         program_view(random_view(), 1'($urandom_range(0, 1)));
         repeat (BLOCK_ITEMS) send_pixel(PIXEL_W'($urandom), PIXEL_W'($urandom));
         drain_results();
      end
   endtask

   // The receiver stops for a long stretch while words keep coming, so the
   // pipeline fills and request words back up.
   task automatic test_output_hold_off();
      view_setting_type s;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      s = random_view();
      s.a_xy = '0;
      s.a_xz = '0;
      s.a_yz = '0;
      program_view(s, 1'b0);
      rsp_hold_cycles = 150;
      repeat (40) send_pixel(PIXEL_W'($urandom), PIXEL_W'($urandom));
      drain_results();
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_voxels.size() == 0) begin
            note_mismatch("result word with nothing outstanding", rsp_data.voxel_address, 0);
         end else begin
            want = expected_voxels.pop_front();
            results_checked++;
            if (want.inside_res) begin
               inside_hits++;
            end
            if (rsp_data.voxel_address !== want.voxel_address) begin
               note_mismatch("voxel_address", rsp_data.voxel_address, want.voxel_address);
            end
            if (rsp_data.inside_res !== want.inside_res) begin
               note_mismatch("inside_res", rsp_data.inside_res, want.inside_res);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word accepted for %0d cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      rsp_hold_cycles = 0;
      quiet_cycles    = 0;
      failures        = 0;
      pixels_sent     = 0;
      results_checked = 0;
      inside_hits     = 0;
      csr_writes      = 0;
      active_view     = '{x_off: '0, y_off: '0, slice: 9'd256, a_xy: '0, a_xz: '0, a_yz: '0};
      for (int r = 0; r <= QUARTER; r++) begin
         quarter_wave[r] = quarter_sine_q(r);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_view();
      test_view_extremes();
      test_rotated_corners();
      test_register_masking();
      test_random_traffic(0, 0, 150);
      test_random_traffic(82, 0, 100);
      test_random_traffic(0, 82, 100);
      test_random_traffic(7, 7, 150);
      test_output_hold_off();

      rsp_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d pixel words and checked %0d results, %0d of them inside the volume.",
               pixels_sent, results_checked, inside_hits);
      $display("Made %0d register writes over extreme, rotated and random views; idle, stall, hold-off.",
               csr_writes);
      if (failures == 0 && expected_voxels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results still outstanding", failures,
                  expected_voxels.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
